@@ design/clc_pkg.sv @@
// ----------------------------------------------------------------------------
// clc_pkg
// shared types, register indexes and reset values of the curing lamp controller
// ----------------------------------------------------------------------------
package clc_pkg;

  // one tick of input
  typedef struct packed {
    logic        switch_pressed;
    logic [15:0] temp_reading;
  } clc_in_t;

  // one tick of output
  typedef struct packed {
    logic led_drive;
    logic fan_drive;
    logic buzzer_drive;
  } clc_out_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEBOUNCE_TICKS    = 3'd0,
    REG_SHORT_BEEP_TICKS  = 3'd1,
    REG_LONG_BEEP_TICKS   = 3'd2,
    REG_REMINDER_TICKS    = 3'd3,
    REG_TEMP_SAMPLE_TICKS = 3'd4,
    REG_FAN_ON_LEVEL      = 3'd5,
    REG_FAN_OFF_LEVEL     = 3'd6
  } clc_reg_t;

  // configuration as seen by the tick logic
  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [7:0]  short_beep_ticks;
    logic [7:0]  long_beep_ticks;
    logic [15:0] reminder_ticks;
    logic [7:0]  temp_sample_ticks;
    logic [15:0] fan_on_level;
    logic [15:0] fan_off_level;
  } clc_cfg_t;

  localparam logic [7:0]  DebounceTicksRst   = 8'd3;
  localparam logic [7:0]  ShortBeepTicksRst  = 8'd7;
  localparam logic [7:0]  LongBeepTicksRst   = 8'd18;
  localparam logic [15:0] ReminderTicksRst   = 16'd368;
  localparam logic [7:0]  TempSampleTicksRst = 8'd40;
  localparam logic [15:0] FanOnLevelRst      = 16'd8500;
  localparam logic [15:0] FanOffLevelRst     = 16'd9400;

endpackage

@@ design/clc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// clc_cfg_regs
// configuration register file, written by index
// ----------------------------------------------------------------------------
module clc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [clc_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [clc_pkg::CfgDataWidth-1:0]  wr_data,
  output clc_pkg::clc_cfg_t                cfg
);
  import clc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= DebounceTicksRst;
      cfg.short_beep_ticks  <= ShortBeepTicksRst;
      cfg.long_beep_ticks   <= LongBeepTicksRst;
      cfg.reminder_ticks    <= ReminderTicksRst;
      cfg.temp_sample_ticks <= TempSampleTicksRst;
      cfg.fan_on_level      <= FanOnLevelRst;
      cfg.fan_off_level     <= FanOffLevelRst;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= wr_data[7:0];
        REG_SHORT_BEEP_TICKS:  cfg.short_beep_ticks  <= wr_data[7:0];
        REG_LONG_BEEP_TICKS:   cfg.long_beep_ticks   <= wr_data[7:0];
        REG_REMINDER_TICKS:    cfg.reminder_ticks    <= wr_data;
        REG_TEMP_SAMPLE_TICKS: cfg.temp_sample_ticks <= wr_data[7:0];
        REG_FAN_ON_LEVEL:      cfg.fan_on_level      <= wr_data;
        REG_FAN_OFF_LEVEL:     cfg.fan_off_level     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/clc_tick.sv @@
// ----------------------------------------------------------------------------
// clc_tick
// controller state and the per-tick update: key, fan, buzzer, reminder
// ----------------------------------------------------------------------------
module clc_tick (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  clc_pkg::clc_cfg_t cfg,
  input  clc_pkg::clc_in_t  tick_in,
  output clc_pkg::clc_out_t tick_out
);
  import clc_pkg::*;

  logic        led_lit, key_locked, debounce_armed, fan_running;
  logic        beep_request, beep_sounding, reminder_armed;
  logic [7:0]  beep_length, debounce_count, sample_count, beep_count;
  logic [15:0] reminder_count;

  logic        led_lit_next, key_locked_next, debounce_armed_next, fan_running_next;
  logic        beep_request_next, beep_sounding_next, reminder_armed_next;
  logic [7:0]  beep_length_next, debounce_count_next, sample_count_next, beep_count_next;
  logic [15:0] reminder_count_next;

  // values after the four steps, before the count-down
  logic [7:0]  dcnt, scnt, bcnt;
  logic [15:0] rcnt;

  always_comb begin
    led_lit_next        = led_lit;
    key_locked_next     = key_locked;
    debounce_armed_next = debounce_armed;
    fan_running_next    = fan_running;
    beep_request_next   = beep_request;
    beep_sounding_next  = beep_sounding;
    reminder_armed_next = reminder_armed;
    beep_length_next    = beep_length;
    dcnt                = debounce_count;
    scnt                = sample_count;
    bcnt                = beep_count;
    rcnt                = reminder_count;

    // key debounce, press toggles the led
    if (!key_locked && tick_in.switch_pressed) begin
      if (!debounce_armed) begin
        dcnt                = cfg.debounce_ticks;
        debounce_armed_next = 1'b1;
      end else if (debounce_count == 8'd0) begin
        debounce_armed_next = 1'b0;
        key_locked_next     = 1'b1;
        led_lit_next        = !led_lit;
        beep_length_next    = cfg.short_beep_ticks;
        beep_request_next   = 1'b1;
      end
    end else if (key_locked && !tick_in.switch_pressed) begin
      if (!debounce_armed) begin
        dcnt                = cfg.debounce_ticks;
        debounce_armed_next = 1'b1;
      end else if (debounce_count == 8'd0) begin
        key_locked_next     = 1'b0;
        debounce_armed_next = 1'b0;
      end
    end

    // fan hysteresis on sample ticks
    if (sample_count == 8'd0) begin
      if (led_lit_next && !fan_running && (tick_in.temp_reading < cfg.fan_on_level)) begin
        fan_running_next = 1'b1;
      end
      if (fan_running_next && (tick_in.temp_reading > cfg.fan_off_level)) begin
        fan_running_next = 1'b0;
      end
      scnt = cfg.temp_sample_ticks;
    end

    // buzzer pulse
    if (!beep_sounding && beep_request_next) begin
      beep_sounding_next = 1'b1;
      bcnt               = beep_length_next;
    end else if ((beep_count == 8'd0) && beep_sounding) begin
      beep_sounding_next = 1'b0;
      beep_request_next  = 1'b0;
    end

    // reminder beep while lit
    if (led_lit_next && !reminder_armed) begin
      rcnt                = cfg.reminder_ticks;
      reminder_armed_next = 1'b1;
    end else if ((reminder_count == 16'd0) && reminder_armed) begin
      beep_length_next    = cfg.long_beep_ticks;
      beep_request_next   = 1'b1;
      reminder_armed_next = 1'b0;
    end else if (!led_lit_next) begin
      reminder_armed_next = 1'b0;
    end

    tick_out.led_drive    = led_lit_next;
    tick_out.fan_drive    = fan_running_next;
    tick_out.buzzer_drive = beep_sounding_next;

    // end-of-tick count-down, saturating at zero
    debounce_count_next = (dcnt != 8'd0) ? dcnt - 8'd1 : 8'd0;
    sample_count_next   = (scnt != 8'd0) ? scnt - 8'd1 : 8'd0;
    beep_count_next     = (bcnt != 8'd0) ? bcnt - 8'd1 : 8'd0;
    reminder_count_next = (rcnt != 16'd0) ? rcnt - 16'd1 : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_lit        <= 1'b0;
      key_locked     <= 1'b0;
      debounce_armed <= 1'b0;
      fan_running    <= 1'b0;
      beep_request   <= 1'b0;
      beep_sounding  <= 1'b0;
      reminder_armed <= 1'b0;
      beep_length    <= 8'd0;
      debounce_count <= 8'd0;
      sample_count   <= 8'd0;
      beep_count     <= 8'd0;
      reminder_count <= 16'd0;
    end else if (step) begin
      led_lit        <= led_lit_next;
      key_locked     <= key_locked_next;
      debounce_armed <= debounce_armed_next;
      fan_running    <= fan_running_next;
      beep_request   <= beep_request_next;
      beep_sounding  <= beep_sounding_next;
      reminder_armed <= reminder_armed_next;
      beep_length    <= beep_length_next;
      debounce_count <= debounce_count_next;
      sample_count   <= sample_count_next;
      beep_count     <= beep_count_next;
      reminder_count <= reminder_count_next;
    end
  end

  // a sounding buzzer always has a pending request behind it
  a_sound_has_request: assert property (@(posedge clk) disable iff (rst)
    beep_sounding |-> beep_request)
    else $error("buzzer sounding without a request");

  // the led only toggles on the tick that locks the key
  a_led_toggle_locks: assert property (@(posedge clk) disable iff (rst)
    (led_lit != $past(led_lit)) |-> (key_locked && !$past(key_locked)))
    else $error("led toggled without a debounced press");

  // the fan only starts while the led is lit
  a_fan_start_lit: assert property (@(posedge clk) disable iff (rst)
    $rose(fan_running) |-> led_lit)
    else $error("fan started with led dark");

endmodule

@@ design/curing_lamp_controller.sv @@
// ----------------------------------------------------------------------------
// curing_lamp_controller
// tick-driven controller for a curing lamp: led, fan and buzzer
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_ready   | in_data  (switch_pressed, temp_reading)
//   out     | out_valid / out_ready | out_data (led_drive, fan_drive, buzzer)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one item per cycle sustained while out_ready holds; an item is taken into the
// input register, and when it advances the tick logic updates the state and
// loads the result register, whose valid flag then shows the result.
// the input register empties whenever the result register is empty or being
// taken, so in_ready stays high while results keep flowing.
// rst (synchronous) clears the state, the two valid flags and restores the
// register reset values; there is no clearing pass.
//
module curing_lamp_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  clc_pkg::clc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output clc_pkg::clc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [clc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import clc_pkg::*;

  clc_cfg_t cfg;
  clc_in_t  in_hold;     // input register payload
  logic     in_full;     // input register holds an item
  logic     advance;     // tick the held item into the result register
  clc_out_t tick_out;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  clc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a held item moves on when the result slot is free or being drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_hold <= in_data;
    end
  end

  clc_tick u_tick (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cfg      (cfg),
    .tick_in  (in_hold),
    .tick_out (tick_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= tick_out;
    end
  end

  // every ticked item lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("ticked item did not reach the result register");

  // a held item is never dropped while the result side is stalled
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("held item lost while stalled");

  // with nothing held the input side is always open
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("input stalled while empty");

endmodule
